[rtl/rpcd_pkg.sv]
package rpcd_pkg;

  // Default header size of a connection-oriented PDU
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic [7:0] EXPECTED_VERSION_RST = 8'd5;

  // Header byte positions
  localparam logic [15:0] VER_POS    = 16'd0;
  localparam logic [15:0] FLAG_POS   = 16'd3;
  localparam logic [15:0] DREP_POS   = 16'd4;
  localparam logic [15:0] LEN_LO_POS = 16'd8;
  localparam logic [15:0] LEN_HI_POS = 16'd9;

  // First and last fragment flags
  localparam logic [7:0] FRAG_MASK = 8'h03;
  // Little-endian integer representation
  localparam logic [7:0] DREP_LE   = 8'h10;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DONE    = 3'd1,
    ST_ZERO    = 3'd2,
    ST_VER_ERR = 3'd3,
    ST_DROP    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       gap_seen;
    logic       segment_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_offset;
    logic [15:0] pdu_length;
    logic        fragmented;
    logic        header_done;
    status_t     status;
    logic        segment_end;
  } out_item_t;

endpackage

[rtl/rpcd_in_if.sv]
interface rpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       gap_seen;
  logic       segment_last;

  modport source (output valid, output stream_byte, output gap_seen, output segment_last,
                  input ready);
  modport sink (input valid, input stream_byte, input gap_seen, input segment_last,
                output ready);
endinterface

[rtl/rpcd_out_if.sv]
interface rpcd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic [15:0]       byte_offset;
  logic [15:0]       pdu_length;
  logic              fragmented;
  logic              header_done;
  rpcd_pkg::status_t status;
  logic              segment_end;

  modport source (output valid, output out_byte, output byte_offset, output pdu_length,
                  output fragmented, output header_done, output status,
                  output segment_end, input ready);
  modport sink (input valid, input out_byte, input byte_offset, input pdu_length,
                input fragmented, input header_done, input status, input segment_end,
                output ready);
endinterface

[rtl/rpcd_cfg_if.sv]
interface rpcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_version;

  modport source (output valid, output expected_version, input ready);
  modport sink (input valid, input expected_version, output ready);
endinterface

[rtl/rpcd_step.sv]
module rpcd_step #(
  parameter int HEADER_BYTES = rpcd_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rpcd_pkg::in_item_t  item,
  input  logic [7:0]          expected_version,
  output rpcd_pkg::out_item_t result
);

  localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  version_byte, version_byte_next;
  logic [7:0]  flag_byte, flag_byte_next;
  logic [7:0]  drep_byte, drep_byte_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  logic        skipping, skipping_next;
  logic        frag_flag, frag_flag_next;

  logic        take;
  logic [15:0] count_inc;

  assign take      = !skipping && !item.gap_seen;
  assign count_inc = byte_count + 16'd1;

  always_comb begin
    byte_count_next      = byte_count;
    frame_length_next    = frame_length;
    version_byte_next    = version_byte;
    flag_byte_next       = flag_byte;
    drep_byte_next       = drep_byte;
    length_low_byte_next = length_low_byte;
    skipping_next        = skipping;
    frag_flag_next       = frag_flag;

    result.out_byte    = item.stream_byte;
    result.segment_end = item.segment_last;
    result.byte_offset = '0;
    result.pdu_length  = '0;
    result.fragmented  = 1'b0;
    result.header_done = 1'b0;
    result.status      = rpcd_pkg::ST_DROP;

    if (take) begin
      result.byte_offset = byte_count;
      byte_count_next    = count_inc;
      result.status      = rpcd_pkg::ST_BUSY;
      if (byte_count < HDR_LEN) begin
        // capture the header fields we care about
        case (byte_count)
          rpcd_pkg::VER_POS:    version_byte_next    = item.stream_byte;
          rpcd_pkg::FLAG_POS:   flag_byte_next       = item.stream_byte;
          rpcd_pkg::DREP_POS:   drep_byte_next       = item.stream_byte;
          rpcd_pkg::LEN_LO_POS: length_low_byte_next = item.stream_byte;
          rpcd_pkg::LEN_HI_POS: begin
            if ((drep_byte & rpcd_pkg::DREP_LE) != 8'd0) begin
              frame_length_next = {item.stream_byte, length_low_byte};
            end else begin
              frame_length_next = {length_low_byte, item.stream_byte};
            end
          end
          default: ;
        endcase
        if (count_inc == HDR_LEN) begin
          result.header_done = 1'b1;
          if (version_byte_next != expected_version) begin
            skipping_next     = 1'b1;
            frame_length_next = '0;
            frag_flag_next    = 1'b0;
            result.status     = rpcd_pkg::ST_VER_ERR;
          end else begin
            frag_flag_next    = (flag_byte_next & rpcd_pkg::FRAG_MASK) != rpcd_pkg::FRAG_MASK;
            result.pdu_length = frame_length_next;
            result.fragmented = frag_flag_next;
            if (frame_length_next == 16'd0) begin
              result.status     = rpcd_pkg::ST_ZERO;
              byte_count_next   = '0;
              frame_length_next = '0;
              frag_flag_next    = 1'b0;
            end else if (frame_length_next <= HDR_LEN) begin
              result.status     = rpcd_pkg::ST_DONE;
              byte_count_next   = '0;
              frame_length_next = '0;
              frag_flag_next    = 1'b0;
            end
          end
        end
      end else begin
        // body byte
        result.pdu_length = frame_length;
        result.fragmented = frag_flag;
        if (count_inc >= frame_length) begin
          result.status     = rpcd_pkg::ST_DONE;
          byte_count_next   = '0;
          frame_length_next = '0;
          frag_flag_next    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      frame_length    <= '0;
      version_byte    <= '0;
      flag_byte       <= '0;
      drep_byte       <= '0;
      length_low_byte <= '0;
      skipping        <= 1'b0;
      frag_flag       <= 1'b0;
    end else if (step) begin
      byte_count      <= byte_count_next;
      frame_length    <= frame_length_next;
      version_byte    <= version_byte_next;
      flag_byte       <= flag_byte_next;
      drep_byte       <= drep_byte_next;
      length_low_byte <= length_low_byte_next;
      skipping        <= skipping_next;
      frag_flag       <= frag_flag_next;
    end
  end

endmodule

[rtl/rpc_pdu_stream_deframer.sv]
// Channel  Dir  Payload                                              Handshake
// src      in   stream_byte[8] gap_seen segment_last                 valid/ready
// dst      out  out_byte[8] byte_offset[16] pdu_length[16]
//               fragmented header_done status[3] segment_end         valid/ready
// cfg      in   expected_version[8]                                  valid/ready
//
// One byte per clock sustained while dst is ready. Each byte passes the input register,
// then the header/body step logic into the result register, which drives dst.valid.
// rst is synchronous: PDU state clears, expected_version returns to 5.
// A stall on dst holds the result register; the input register still takes one
// more byte, then src.ready drops until dst frees up.
// cfg is always ready; a write lands on the next edge.

module rpc_pdu_stream_deframer #(
  parameter int HEADER_BYTES = rpcd_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rpcd_in_if.sink     src,
  rpcd_out_if.source  dst,
  rpcd_cfg_if.sink    cfg
);

  // Configuration register
  logic [7:0] expected_version;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= rpcd_pkg::EXPECTED_VERSION_RST;
    end else if (cfg.valid) begin
      expected_version <= cfg.expected_version;
    end
  end

  // Input register
  logic                s1_valid;
  rpcd_pkg::in_item_t  s1_item;

  // Result register
  logic                out_valid;
  rpcd_pkg::out_item_t out_item;

  logic                out_free;
  logic                advance;
  rpcd_pkg::out_item_t res;

  assign out_free  = !out_valid || dst.ready;
  assign advance   = s1_valid && out_free;
  assign src.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.valid && src.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      s1_item.stream_byte  <= src.stream_byte;
      s1_item.gap_seen     <= src.gap_seen;
      s1_item.segment_last <= src.segment_last;
    end
  end

  // PDU tracking: header capture, length decode, body count.
  // State moves only when a byte goes into the result register.
  rpcd_step #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_step (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .item             (s1_item),
    .expected_version (expected_version),
    .result           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.out_byte    = out_item.out_byte;
  assign dst.byte_offset = out_item.byte_offset;
  assign dst.pdu_length  = out_item.pdu_length;
  assign dst.fragmented  = out_item.fragmented;
  assign dst.header_done = out_item.header_done;
  assign dst.status      = out_item.status;
  assign dst.segment_end = out_item.segment_end;

`ifndef NO_ASSERTIONS
  // a version error locks the block: the next stepped byte is dropped
  a_skip_after_err: assert property (@(posedge clk) disable iff (rst)
    advance && res.status == rpcd_pkg::ST_VER_ERR |=>
      !advance || res.status == rpcd_pkg::ST_DROP)
    else $error("byte taken after version error");

  // body end lands exactly on the last byte of the fragment
  a_body_end: assert property (@(posedge clk) disable iff (rst)
    advance && res.status == rpcd_pkg::ST_DONE && !res.header_done |->
      ({1'b0, res.byte_offset} + 17'd1) == {1'b0, res.pdu_length})
    else $error("PDU end off length");

  // a buffered byte is never overwritten while the result is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost a byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dst.ready |=> out_valid && $stable(out_item))
    else $error("result register lost a byte");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;

  localparam int HDR        = rpcd_pkg::HEADER_BYTES_DEF;
  localparam int HDR_IDX_W  = $clog2(HDR);
  localparam int QUIET_MAX  = 1000;   // cycles with no transfer anywhere
  localparam int TAIL_WAIT  = 10;     // settle time after the last echo
  localparam int PHASE_BYTES = 320;

  // Tracks PDU framing the way the deframer should, one echo per byte.
  class pdu_echo_board;
    rpcd_pkg::out_item_t expected_echoes[$];
    logic [7:0]  want_version;
    logic [15:0] taken;
    logic [15:0] cur_length;
    logic [7:0]  ver_byte;
    logic [7:0]  flag_bits;
    logic [7:0]  drep_bits;
    logic [7:0]  len_first;
    bit          skip_rest;
    bit          frag_now;
    int          mismatches;

    function new();
      want_version = rpcd_pkg::EXPECTED_VERSION_RST;
      taken        = '0;
      cur_length   = '0;
      ver_byte     = '0;
      flag_bits    = '0;
      drep_bits    = '0;
      len_first    = '0;
      skip_rest    = 1'b0;
      frag_now     = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_version(logic [7:0] v);
      want_version = v;
    endfunction

    function void close_pdu();
      taken      = '0;
      cur_length = '0;
      frag_now   = 1'b0;
    endfunction

    // Accepted input byte: advance the framing state, queue the echo it causes.
    function void note_byte(rpcd_pkg::in_item_t it);
      rpcd_pkg::out_item_t e;
      logic [7:0] b;
      b = it.stream_byte;
      e = '0;
      e.out_byte    = b;
      e.segment_end = it.segment_last;
      e.status      = rpcd_pkg::ST_DROP;
      if (!skip_rest && !it.gap_seen) begin
        e.byte_offset = taken;
        if (taken < HDR) begin
          case (taken)
            rpcd_pkg::VER_POS:    ver_byte  = b;
            rpcd_pkg::FLAG_POS:   flag_bits = b;
            rpcd_pkg::DREP_POS:   drep_bits = b;
            rpcd_pkg::LEN_LO_POS: len_first = b;
            rpcd_pkg::LEN_HI_POS: begin
              if ((drep_bits & rpcd_pkg::DREP_LE) != 0) cur_length = {b, len_first};
              else cur_length = {len_first, b};
            end
            default: ;
          endcase
          taken    = taken + 16'd1;
          e.status = rpcd_pkg::ST_BUSY;
          if (taken == HDR) begin
            e.header_done = 1'b1;
            if (ver_byte != want_version) begin
              // bad version: everything after this is dropped for good
              skip_rest  = 1'b1;
              cur_length = '0;
              frag_now   = 1'b0;
              e.status   = rpcd_pkg::ST_VER_ERR;
            end else begin
              frag_now     = (flag_bits & rpcd_pkg::FRAG_MASK) != rpcd_pkg::FRAG_MASK;
              e.pdu_length = cur_length;
              e.fragmented = frag_now;
              if (cur_length == 0) begin
                e.status = rpcd_pkg::ST_ZERO;
                close_pdu();
              end else if (cur_length <= HDR) begin
                e.status = rpcd_pkg::ST_DONE;
                close_pdu();
              end
            end
          end
        end else begin
          e.pdu_length = cur_length;
          e.fragmented = frag_now;
          taken        = taken + 16'd1;
          e.status     = rpcd_pkg::ST_BUSY;
          if (taken >= cur_length) begin
            e.status = rpcd_pkg::ST_DONE;
            close_pdu();
          end
        end
      end
      expected_echoes.push_back(e);
    endfunction

    function void check_echo(rpcd_pkg::out_item_t got);
      rpcd_pkg::out_item_t e;
      if (expected_echoes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected echo byte=%02h off=%0d len=%0d frag=%0b hd=%0b st=%0d seg=%0b",
                   got.out_byte, got.byte_offset, got.pdu_length, got.fragmented,
                   got.header_done, got.status, got.segment_end);
        return;
      end
      e = expected_echoes.pop_front();
      if (got.out_byte !== e.out_byte || got.byte_offset !== e.byte_offset ||
          got.pdu_length !== e.pdu_length || got.fragmented !== e.fragmented ||
          got.header_done !== e.header_done || got.status !== e.status ||
          got.segment_end !== e.segment_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: echo mismatch at %0t", $realtime);
          $display("  expected byte=%02h off=%0d len=%0d frag=%0b hd=%0b st=%0d seg=%0b",
                   e.out_byte, e.byte_offset, e.pdu_length, e.fragmented,
                   e.header_done, e.status, e.segment_end);
          $display("  actual   byte=%02h off=%0d len=%0d frag=%0b hd=%0b st=%0d seg=%0b",
                   got.out_byte, got.byte_offset, got.pdu_length, got.fragmented,
                   got.header_done, got.status, got.segment_end);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rpcd_in_if  src_if ();
  rpcd_out_if dst_if ();
  rpcd_cfg_if cfg_if ();

  rpc_pdu_stream_deframer #(
    .HEADER_BYTES(HDR)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .src(src_if),
    .dst(dst_if),
    .cfg(cfg_if)
  );

  pdu_echo_board       board;
  rpcd_pkg::out_item_t seen;
  int                  quiet_cycles;
  int                  bytes_taken;    // non-gap bytes accepted
  int                  src_idle_pct;
  int                  dst_idle_pct;
  bit                  no_idle;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Sink side: ready drops in bursts of random length.
  initial begin
    dst_if.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(99) < dst_idle_pct) begin
        dst_if.ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        dst_if.ready <= 1'b1;
      end
    end
  end

  // Echo monitor and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (dst_if.valid && dst_if.ready) begin
        seen.out_byte    = dst_if.out_byte;
        seen.byte_offset = dst_if.byte_offset;
        seen.pdu_length  = dst_if.pdu_length;
        seen.fragmented  = dst_if.fragmented;
        seen.header_done = dst_if.header_done;
        seen.status      = dst_if.status;
        seen.segment_end = dst_if.segment_end;
        board.check_echo(seen);
      end
      if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One transfer on src, with an optional idle burst ahead of it.
  task automatic send_item(input logic [7:0] b, input logic gap, input logic seg);
    rpcd_pkg::in_item_t it;
    it.stream_byte  = b;
    it.gap_seen     = gap;
    it.segment_last = seg;
    if (!no_idle && $urandom_range(99) < src_idle_pct) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    src_if.valid        <= 1'b1;
    src_if.stream_byte  <= it.stream_byte;
    src_if.gap_seen     <= it.gap_seen;
    src_if.segment_last <= it.segment_last;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    board.note_byte(it);
    if (!gap) bytes_taken++;
    @(negedge clk);
  endtask

  // Stream byte, sometimes preceded by a gap byte that must be dropped.
  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(19) == 0)
      send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    send_item(b, 1'b0, $urandom_range(7) == 0);
  endtask

  task automatic send_pdu(input logic [7:0] ver, input int unsigned len);
    logic [7:0] hdr [HDR];
    logic [15:0] flen;
    flen = len[15:0];
    foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
    hdr[rpcd_pkg::VER_POS[HDR_IDX_W-1:0]] = ver;
    if ($urandom_range(1))
      hdr[rpcd_pkg::FLAG_POS[HDR_IDX_W-1:0]] =
        hdr[rpcd_pkg::FLAG_POS[HDR_IDX_W-1:0]] | rpcd_pkg::FRAG_MASK;
    if ((hdr[rpcd_pkg::DREP_POS[HDR_IDX_W-1:0]] & rpcd_pkg::DREP_LE) != 0) begin
      hdr[rpcd_pkg::LEN_LO_POS[HDR_IDX_W-1:0]] = flen[7:0];
      hdr[rpcd_pkg::LEN_HI_POS[HDR_IDX_W-1:0]] = flen[15:8];
    end else begin
      hdr[rpcd_pkg::LEN_LO_POS[HDR_IDX_W-1:0]] = flen[15:8];
      hdr[rpcd_pkg::LEN_HI_POS[HDR_IDX_W-1:0]] = flen[7:0];
    end
    foreach (hdr[i]) send_data(hdr[i]);
    for (int unsigned i = HDR; i < len; i++) send_data(8'($urandom_range(255)));
  endtask

  // Whole PDUs with a spread of lengths: zero, within the header, one past
  // the header, short bodies and the odd long one.
  task automatic run_phase(input logic [7:0] ver, input int n_bytes);
    int stop_at;
    int pick;
    int unsigned len;
    stop_at = bytes_taken + n_bytes;
    while (bytes_taken < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 0;
      else if (pick < 24) len = $urandom_range(1, HDR);
      else if (pick < 32) len = HDR + 1;
      else if (pick < 95) len = $urandom_range(HDR + 2, 40);
      else                len = $urandom_range(41, 200);
      send_pdu(ver, len);
    end
  endtask

  task automatic drain();
    src_if.valid <= 1'b0;
    while (board.expected_echoes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes only with nothing in flight.
  task automatic write_version(input logic [7:0] v);
    drain();
    cfg_if.valid            <= 1'b1;
    cfg_if.expected_version <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.set_version(v);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] zero_hdr [HDR];
    board        = new();
    rst          = 1'b1;
    no_idle      = 1'b0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    bytes_taken  = 0;
    src_if.valid            = 1'b0;
    src_if.stream_byte      = '0;
    src_if.gap_seen         = 1'b0;
    src_if.segment_last     = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.expected_version = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: gap bytes with extreme values, then a zero-length header
    // (little endian, both fragment flags set) under the reset version.
    zero_hdr = '{8'h05, 8'hFF, 8'h00, 8'h03, 8'h10, 8'hFF, 8'h00, 8'hAA,
                 8'h00, 8'h00, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    foreach (zero_hdr[i]) send_item(zero_hdr[i], 1'b0, (i % 5) == 0);

    src_idle_pct = 10;
    dst_idle_pct = 10;
    run_phase(rpcd_pkg::EXPECTED_VERSION_RST, PHASE_BYTES);

    write_version(8'h00);
    src_idle_pct = 25;
    dst_idle_pct = 5;
    run_phase(8'h00, PHASE_BYTES);

    write_version(8'hFF);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_phase(8'hFF, PHASE_BYTES);

    begin
      logic [7:0] v;
      v = 8'($urandom_range(255));
      write_version(v);
      src_idle_pct = 5;
      dst_idle_pct = 30;
      run_phase(v, PHASE_BYTES);
    end

    // Last part runs at full rate and ends in a version error, after which
    // every byte, gap or not, comes back dropped.
    write_version(rpcd_pkg::EXPECTED_VERSION_RST);
    no_idle = 1'b1;
    run_phase(rpcd_pkg::EXPECTED_VERSION_RST, PHASE_BYTES);
    send_pdu(rpcd_pkg::EXPECTED_VERSION_RST + 8'd1, $urandom_range(0, 64));
    repeat (24)
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (board.mismatches == 0 && board.expected_echoes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
